// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/jcr_pkg.sv =====
// ----------------------------------------------------------------------------
// Joybus command responder package
// Shared constants and types.
// ----------------------------------------------------------------------------
package jcr_pkg;
    localparam int BlockBytes = 64;
    localparam int PakBytes = 32768;
    localparam int PakAw = $clog2(PakBytes);
    localparam logic [7:0] TxSkip = 8'h00;
    localparam logic [7:0] TxEnd = 8'hFE;
    localparam logic [7:0] TxPadA = 8'hFD;
    localparam logic [7:0] TxPadB = 8'hFF;
    localparam logic [7:0] CmdInfo = 8'h00;
    localparam logic [7:0] CmdInfoB = 8'hFF;
    localparam logic [7:0] CmdPad = 8'h01;
    localparam logic [7:0] CmdRead = 8'h02;
    localparam logic [7:0] CmdWrite = 8'h03;
    localparam logic [7:0] CrcPoly = 8'h85;
    localparam logic [7:0] ErrFlag = 8'h80;

    typedef enum logic [4:0] {
        S_IDLE, S_COPY, S_TX, S_RX, S_CMD, S_A1, S_A2, S_DISPATCH,
        S_INFO, S_PAD, S_RDMEM, S_RDWR, S_WRRD, S_WRMEM, S_CRCRD, S_CRCBIT,
        S_CRCPUT, S_FLAG, S_NEXT, S_DONE, S_EMIT, S_EMITW
    } state_t;

    function automatic logic [7:0] crc_step(logic [7:0] crc, logic din);
        logic [7:0] x;
        x = crc[7] ? CrcPoly : 8'h00;
        return {crc[6:0], din} ^ x;
    endfunction
endpackage

// ===== rtl/core/jcr_pak_ram.sv =====
// ----------------------------------------------------------------------------
// Controller pak storage
// Single-port byte memory with registered read; the responder zero-fills it after reset.
// ----------------------------------------------------------------------------
module jcr_pak_ram import jcr_pkg::*; (
    input  logic             clk,
    input  logic             we,
    input  logic [PakAw-1:0] addr,
    input  logic [7:0]       wdata,
    output logic [7:0]       rdata
);
    logic [7:0] mem [PakBytes];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/core/joybus_command_responder.sv =====
// ----------------------------------------------------------------------------
// Joybus command responder
// A sequencer walks the 64-byte block one byte per step, with a bit-serial
// CRC unit and a pak memory. Both 64-byte blocks are read through a
// registered read port. After reset a clearing pass zeroes the pak and the
// command block before any request is taken. A load request stores one
// byte; the 64th also runs the walk: a copy of the command block into the
// response block, one step per skipped or padding byte, a short sequence
// per info, pad or flagged command, and a memory pass plus a bit-serial CRC
// over 33 bytes per pak read or write. It then offers a single completion
// response. A read request runs the same walk and then emits 64 bytes, one
// per accepted output cycle. The input is not ready during a walk.
// ----------------------------------------------------------------------------
module joybus_command_responder import jcr_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pak_inserted_we,
    input  logic        pak_inserted_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // cmd_byte, pad_buttons, stick_x, stick_y, pad_ok
    input  logic        s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // out_byte
    output logic [2:0]  m_axis_tuser,  // byte_valid, rumble_valid, rumble_on
    output logic        m_axis_tlast   // last
);
    state_t state_reg, state_next;
    logic pak_reg;
    logic clr_reg;
    logic [PakAw:0] clr_cnt_reg;
    logic [7:0] cmem [BlockBytes];
    logic [7:0] rmem [BlockBytes];
    logic [7:0] cm_rd_reg;
    logic [7:0] rd_reg;
    logic [5:0] lpos_reg;
    logic replay_reg;
    logic [15:0] btn_reg;
    logic [7:0] sx_reg, sy_reg;
    logic ok_reg;
    logic [6:0] i_reg, co_reg;
    logic [6:0] i_next;
    logic [8:0] ro_reg;
    logic [7:0] tx_reg, cmd_reg;
    logic [5:0] rx_reg;
    logic [6:0] channel_reg;
    logic [15:0] addr_reg;
    logic [5:0] k_reg;
    logic [2:0] bit_reg;
    logic [7:0] crc_reg, d_reg;
    logic rv_reg, ron_reg;
    logic [7:0] rbyte;
    logic [7:0] pak_rd;
    logic pak_we;
    logic [PakAw-1:0] pak_addr;
    logic [7:0] pak_wd;
    logic [16:0] pak_lin;
    logic in_range;

    wire accept = s_axis_tvalid && s_axis_tready;
    wire act = s_axis_tuser;

    assign s_axis_tready = (state_reg == S_IDLE) && !clr_reg;
    assign rbyte = rd_reg;
    assign pak_lin = {1'b0, addr_reg} + {11'd0, k_reg};
    assign in_range = !addr_reg[15] && (pak_lin < 17'(PakBytes));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pak_reg <= 1'b1;
            clr_reg <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (pak_inserted_we)
            begin
                pak_reg <= pak_inserted_wdata;
            end
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == (PakAw+1)'(PakBytes - 1))
                begin
                    clr_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_reg)
        begin
            cmem[clr_cnt_reg[5:0]] <= 8'h00;
        end
        else if (accept && !act)
        begin
            cmem[lpos_reg] <= s_axis_tdata[7:0];
        end
        cm_rd_reg <= cmem[i_next[5:0]];
    end

    always_comb
    begin
        pak_we = 1'b0;
        pak_wd = rbyte;
        pak_addr = pak_lin[PakAw-1:0];
        if (clr_reg)
        begin
            pak_we = 1'b1;
            pak_wd = 8'h00;
            pak_addr = clr_cnt_reg[PakAw-1:0];
        end
        else if (state_reg == S_WRMEM)
        begin
            pak_we = 1'b1;
        end
    end

    jcr_pak_ram u_ram (
        .clk(clk), .we(pak_we), .addr(pak_addr), .wdata(pak_wd), .rdata(pak_rd)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (act || lpos_reg == 6'd63)
                    begin
                        state_next = S_COPY;
                    end
                end
            end
            S_COPY: if (i_reg == 7'd63) state_next = S_TX;
            S_TX:
            begin
                if (i_reg >= 7'd63 || rbyte == TxEnd) state_next = S_DONE;
                else if (rbyte == TxSkip || rbyte == TxPadA || rbyte == TxPadB)
                    state_next = S_TX;
                else if (i_reg + 7'd1 >= 7'd63) state_next = S_DONE;
                else state_next = S_RX;
            end
            S_RX: state_next = S_CMD;
            S_CMD:
            begin
                if (ro_reg + {3'b000, rx_reg} > 9'd63) state_next = S_DONE;
                else state_next = S_A1;
            end
            S_A1: state_next = S_A2;
            S_A2: state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                if (!(channel_reg == 7'd0 && ok_reg)) state_next = S_FLAG;
                else if (cmd_reg == CmdInfo || cmd_reg == CmdInfoB)
                    state_next = (rx_reg >= 6'd3) ? S_INFO : S_NEXT;
                else if (cmd_reg == CmdPad)
                    state_next = (rx_reg >= 6'd4) ? S_PAD : S_NEXT;
                else if (cmd_reg == CmdRead)
                    state_next = (rx_reg >= 6'd33) ? S_RDMEM : S_NEXT;
                else if (cmd_reg == CmdWrite)
                    state_next = (!replay_reg && !addr_reg[15] &&
                                  ({1'b0, addr_reg} + 17'd32 <= 17'(PakBytes)))
                                 ? S_WRRD : S_CRCRD;
                else state_next = S_FLAG;
            end
            S_INFO: if (k_reg == 6'd2) state_next = S_NEXT;
            S_PAD: if (k_reg == 6'd3) state_next = S_NEXT;
            S_RDMEM: state_next = S_RDWR;
            S_RDWR: state_next = (k_reg == 6'd31) ? S_CRCRD : S_RDMEM;
            S_WRRD: state_next = S_WRMEM;
            S_WRMEM: state_next = (k_reg == 6'd31) ? S_CRCRD : S_WRRD;
            S_CRCRD: state_next = S_CRCBIT;
            S_CRCBIT:
            begin
                if (bit_reg == 3'd0)
                begin
                    state_next = (k_reg == 6'd32) ? S_CRCPUT : S_CRCRD;
                end
            end
            S_CRCPUT: state_next = S_NEXT;
            S_FLAG: state_next = S_NEXT;
            S_NEXT: state_next = S_TX;
            S_DONE: state_next = replay_reg ? S_EMIT : S_EMITW;
            S_EMIT:
                if (m_axis_tready && i_reg == 7'd63) state_next = S_IDLE;
            S_EMITW: if (m_axis_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        i_next = i_reg;
        unique case (state_reg)
            S_IDLE: i_next = '0;
            S_COPY: i_next = (i_reg == 7'd63) ? 7'd0 : i_reg + 7'd1;
            S_TX: i_next = i_reg + 7'd1;
            S_RX: i_next = i_reg + 7'd1;
            S_CMD: i_next = co_reg + 7'd1;
            S_A1: i_next = co_reg + 7'd2;
            S_A2: i_next = (cmd_reg == CmdWrite) ? co_reg + 7'd3 : ro_reg[6:0];
            S_DISPATCH:
            begin
                if (state_next == S_FLAG) i_next = co_reg - 7'd1;
            end
            S_RDWR: if (k_reg == 6'd31) i_next = ro_reg[6:0];
            S_WRMEM: i_next = (k_reg == 6'd31) ? co_reg + 7'd3 : i_reg + 7'd1;
            S_CRCBIT: if (bit_reg == 3'd0) i_next = i_reg + 7'd1;
            S_NEXT: i_next = ro_reg[6:0] + {1'b0, rx_reg};
            S_DONE: i_next = '0;
            S_EMIT: if (m_axis_tready) i_next = i_reg + 7'd1;
            default: i_next = i_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lpos_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && !act)
            begin
                lpos_reg <= lpos_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
        rd_reg <= rmem[i_next[5:0]];
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    replay_reg <= act;
                    btn_reg <= s_axis_tdata[23:8];
                    sx_reg <= s_axis_tdata[31:24];
                    sy_reg <= s_axis_tdata[39:32];
                    ok_reg <= s_axis_tdata[40];
                end
                rv_reg <= 1'b0;
                ron_reg <= 1'b0;
                channel_reg <= '0;
            end
            S_COPY:
            begin
                rmem[i_reg[5:0]] <= cm_rd_reg;
            end
            S_TX:
            begin
                tx_reg <= rbyte;
                if (rbyte == TxSkip)
                begin
                    channel_reg <= channel_reg + 7'd1;
                end
            end
            S_RX:
            begin
                rx_reg <= rbyte[5:0];
                co_reg <= i_reg + 7'd1;
                ro_reg <= {2'b00, i_reg} + 9'd1 + {1'b0, tx_reg};
            end
            S_CMD:
            begin
                cmd_reg <= rbyte;
            end
            S_A1:
            begin
                addr_reg[15:8] <= rbyte;
            end
            S_A2:
            begin
                addr_reg[7:0] <= rbyte & 8'hE0;
                k_reg <= '0;
                crc_reg <= '0;
                bit_reg <= 3'd7;
            end
            S_DISPATCH:
            begin
                if (!replay_reg && cmd_reg == CmdWrite && addr_reg[15:14] == 2'b11
                    && channel_reg == 7'd0 && ok_reg)
                begin
                    rv_reg <= 1'b1;
                    ron_reg <= rbyte != 8'h00;
                end
            end
            S_INFO:
            begin
                rmem[ro_reg[5:0] + k_reg] <= (k_reg == 6'd0) ? 8'h05 :
                    (k_reg == 6'd1) ? 8'h00 : (pak_reg ? 8'h01 : 8'h02);
                k_reg <= k_reg + 6'd1;
            end
            S_PAD:
            begin
                rmem[ro_reg[5:0] + k_reg] <= (k_reg == 6'd0) ? btn_reg[15:8] :
                    (k_reg == 6'd1) ? btn_reg[7:0] : (k_reg == 6'd2) ? sx_reg : sy_reg;
                k_reg <= k_reg + 6'd1;
            end
            S_RDMEM: ;
            S_RDWR:
            begin
                rmem[ro_reg[5:0] + k_reg] <= in_range ? pak_rd : 8'h00;
                if (k_reg == 6'd31) k_reg <= '0;
                else k_reg <= k_reg + 6'd1;
            end
            S_WRRD: ;
            S_WRMEM:
            begin
                if (k_reg == 6'd31) k_reg <= '0;
                else k_reg <= k_reg + 6'd1;
            end
            S_CRCRD:
            begin
                d_reg <= (k_reg == 6'd32) ? 8'h00 : rbyte;
                bit_reg <= 3'd7;
            end
            S_CRCBIT:
            begin
                crc_reg <= crc_step(crc_reg, d_reg[bit_reg]);
                bit_reg <= bit_reg - 3'd1;
                if (bit_reg == 3'd0)
                begin
                    k_reg <= k_reg + 6'd1;
                end
            end
            S_CRCPUT:
            begin
                if (cmd_reg == CmdRead || rx_reg != 6'd0)
                begin
                    rmem[ro_reg[5:0] + ((cmd_reg == CmdRead) ? 6'd32 : 6'd0)] <= crc_reg;
                end
            end
            S_FLAG:
            begin
                rmem[co_reg[5:0] - 6'd1] <= rbyte | ErrFlag;
            end
            S_NEXT:
            begin
                channel_reg <= channel_reg + 7'd1;
            end
            S_DONE: ;
            S_EMIT: ;
            S_EMITW: ;
            default: ;
        endcase
    end

    always_comb
    begin
        m_axis_tvalid = (state_reg == S_EMIT) || (state_reg == S_EMITW);
        m_axis_tdata = (state_reg == S_EMIT) ? rd_reg : 8'h00;
        m_axis_tuser = (state_reg == S_EMIT) ? 3'b001 : {ron_reg, rv_reg, 1'b0};
        m_axis_tlast = (state_reg == S_EMITW) || (state_reg == S_EMIT && i_reg == 7'd63);
    end

`include "assert_macros.svh"
    `ASSERT_IMPL(a_no_ready_busy, state_reg != S_IDLE, !s_axis_tready)
    `ASSERT_IMPL(a_emit_idx, state_reg == S_EMIT, i_reg < 7'd64)
    `ASSERT_IMPL(a_clear_block, clr_reg, !s_axis_tready)
endmodule

// ===== tb/joybus_command_responder_checker.sv =====
// ----------------------------------------------------------------------------
// Joybus command responder checker
// Watches the request and response streams, keeps its own copy of the
// command block, the response block and the pak memory, works out the bytes
// each accepted request must produce and compares them in order.
// ----------------------------------------------------------------------------
module joybus_command_responder_checker import jcr_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pak_inserted_we,
    input  logic        pak_inserted_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       last;
        logic       rumble_valid;
        logic       rumble_on;
    } response_t;

    localparam logic ActLoad = 1'b0;

    response_t  resp_q[$];
    logic [7:0] cmd_blk[BlockBytes];
    logic [7:0] rsp_blk[BlockBytes];
    logic [7:0] pak_mem[PakBytes];
    logic [5:0] load_pos;
    logic       pak_in;
    logic       rumble_valid;
    logic       rumble_on;

    function automatic logic [7:0] block_crc(int start);
        logic [7:0] crc;
        logic [7:0] d;
        crc = 8'h00;
        for (int k = 0; k <= 32; k++) begin
            d = (k < 32) ? rsp_blk[(start + k) & 63] : 8'h00;
            for (int b = 7; b >= 0; b--)
                crc = {crc[6:0], d[b]} ^ (crc[7] ? CrcPoly : 8'h00);
        end
        return crc;
    endfunction

    task automatic walk_block(input logic replay, input logic [15:0] buttons,
                              input logic [7:0] sx, input logic [7:0] sy,
                              input logic ok);
        int chan;
        int i;
        int rx;
        int co;
        int ro;
        int addr;
        int po;
        logic [7:0] tx;
        logic [7:0] cmd;
        chan = 0;
        i = 0;
        rumble_valid = 1'b0;
        rumble_on = 1'b0;
        while (i < BlockBytes - 1) begin
            tx = rsp_blk[i];
            if (tx == TxSkip) begin
                chan++;
                i++;
                continue;
            end
            if (tx == TxEnd) break;
            if (tx == TxPadA || tx == TxPadB) begin
                i++;
                continue;
            end
            if (i + 1 >= BlockBytes - 1) break;
            rx = rsp_blk[i + 1] & 8'h3F;
            co = i + 2;
            ro = co + tx;
            if (ro + rx > BlockBytes - 1) break;
            cmd = rsp_blk[co];
            if (!(chan == 0 && ok)) begin
                rsp_blk[i + 1] |= ErrFlag;
            end else if (cmd == CmdInfo || cmd == CmdInfoB) begin
                if (rx >= 3) begin
                    rsp_blk[ro] = 8'h05;
                    rsp_blk[ro + 1] = 8'h00;
                    rsp_blk[ro + 2] = pak_in ? 8'h01 : 8'h02;
                end
            end else if (cmd == CmdPad) begin
                if (rx >= 4) begin
                    rsp_blk[ro] = buttons[15:8];
                    rsp_blk[ro + 1] = buttons[7:0];
                    rsp_blk[ro + 2] = sx;
                    rsp_blk[ro + 3] = sy;
                end
            end else if (cmd == CmdRead || cmd == CmdWrite) begin
                addr = {rsp_blk[(co + 1) & 63], rsp_blk[(co + 2) & 63]} & 16'hFFE0;
                if (cmd == CmdRead) begin
                    if (rx >= 33) begin
                        for (int b = 0; b < 32; b++)
                            rsp_blk[ro + b] = (addr < 'h8000 && addr + b < PakBytes)
                                              ? pak_mem[addr + b] : 8'h00;
                        rsp_blk[ro + 32] = block_crc(ro);
                    end
                end else begin
                    po = co + 3;
                    if (!replay) begin
                        if (addr >= 'hC000) begin
                            rumble_valid = 1'b1;
                            rumble_on = rsp_blk[po & 63] != 8'h00;
                        end else if (addr < 'h8000 && addr + 32 <= PakBytes) begin
                            for (int b = 0; b < 32; b++)
                                pak_mem[addr + b] = rsp_blk[(po + b) & 63];
                        end
                    end
                    if (rx >= 1) rsp_blk[ro] = block_crc(po);
                end
            end else begin
                rsp_blk[i + 1] |= ErrFlag;
            end
            chan++;
            i = ro + rx;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        response_t got;
        response_t want;
        if (!rst_n) begin
            foreach (cmd_blk[k]) cmd_blk[k] = 8'h00;
            foreach (pak_mem[k]) pak_mem[k] = 8'h00;
            load_pos = '0;
            pak_in = 1'b1;
            resp_q.delete();
            errors <= 0;
            pending <= 0;
        end else begin
            if (pak_inserted_we) pak_in = pak_inserted_wdata;
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == ActLoad) begin
                    cmd_blk[load_pos] = s_axis_tdata[7:0];
                    load_pos = load_pos + 1'b1;
                    if (load_pos == 0) begin
                        rsp_blk = cmd_blk;
                        walk_block(1'b0, s_axis_tdata[23:8], s_axis_tdata[31:24],
                                   s_axis_tdata[39:32], s_axis_tdata[40]);
                        resp_q.push_back('{8'h00, 1'b0, 1'b1, rumble_valid, rumble_on});
                    end
                end else begin
                    rsp_blk = cmd_blk;
                    walk_block(1'b1, s_axis_tdata[23:8], s_axis_tdata[31:24],
                               s_axis_tdata[39:32], s_axis_tdata[40]);
                    for (int k = 0; k < BlockBytes; k++)
                        resp_q.push_back('{rsp_blk[k], 1'b1, k == BlockBytes - 1,
                                           1'b0, 1'b0});
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tlast,
                        m_axis_tuser[1], m_axis_tuser[2]};
                if (resp_q.size() == 0) begin
                    $error("response with nothing expected: out_byte %h", got.data);
                    errors <= errors + 1;
                end else begin
                    want = resp_q.pop_front();
                    if (got != want) begin
                        errors <= errors + 1;
                        if (got.data != want.data)
                            $error("out_byte: expected %h, got %h", want.data, got.data);
                        if (got.byte_valid != want.byte_valid)
                            $error("byte_valid: expected %b, got %b",
                                   want.byte_valid, got.byte_valid);
                        if (got.last != want.last)
                            $error("last: expected %b, got %b", want.last, got.last);
                        if (got.rumble_valid != want.rumble_valid)
                            $error("rumble_valid: expected %b, got %b",
                                   want.rumble_valid, got.rumble_valid);
                        if (got.rumble_on != want.rumble_on)
                            $error("rumble_on: expected %b, got %b",
                                   want.rumble_on, got.rumble_on);
                    end
                end
            end
            pending <= resp_q.size();
        end
    end
endmodule

// ===== tb/joybus_command_responder_tb.sv =====
// ----------------------------------------------------------------------------
// Joybus command responder testbench
// Loads directed and random command blocks with info, pad, pak read and write
// and rumble commands, replays them with read requests, changes the pak
// setting between phases, and stalls both streams at random.
// ----------------------------------------------------------------------------
module joybus_command_responder_tb;
    import jcr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ActLoad = 1'b0;
    localparam logic ActRead = 1'b1;
    localparam int CycleLimit = 4000000;

    logic        clk;
    logic        rst_n;
    logic        pak_inserted_we;
    logic        pak_inserted_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // cmd_byte, pad_buttons, stick_x, stick_y, pad_ok
    logic        s_axis_tuser;   // action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // out_byte
    logic [2:0]  m_axis_tuser;   // byte_valid, rumble_valid, rumble_on
    logic        m_axis_tlast;   // last
    int          errors;
    int          pending;
    int          cycles;
    logic        quiet;
    logic        hold_req;
    logic [7:0]  blk[BlockBytes];

    joybus_command_responder u_top (.*);

    joybus_command_responder_checker u_chk (.*);

    always begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        gap = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (3000) @(posedge clk);
            end
            if (gap > 0) begin
                gap--;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 18) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send(input logic act, input logic [7:0] data);
        logic [47:0] word;
        logic ok;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        ok = ($urandom_range(0, 7) != 0);
        word = '0;
        word[40:0] = {ok, 8'($urandom), 8'($urandom), 16'($urandom), data};
        s_axis_tdata <= word;
        s_axis_tuser <= act;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_pak(input logic v);
        drain();
        pak_inserted_we <= 1'b1;
        pak_inserted_wdata <= v;
        @(posedge clk);
        pak_inserted_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_addr();
        logic [15:0] a;
        case ($urandom_range(0, 5))
            0: a = 16'h0000;
            1: a = 16'h0020;
            2: a = 16'h7FE0;
            3: a = 16'h8000 | 16'($urandom_range(0, 'h3FFF));
            4: a = 16'hC000 | 16'($urandom_range(0, 'h3FFF));
            default: a = 16'($urandom);
        endcase
        return a | 16'($urandom_range(0, 31));
    endfunction

    task automatic make_block();
        int p;
        int len;
        logic [15:0] a;
        foreach (blk[k]) blk[k] = 8'($urandom);
        if ($urandom_range(0, 5) == 0) return;
        p = 0;
        while (p < 63) begin
            case ($urandom_range(0, 9))
                0: begin blk[p] = TxSkip; len = 1; end
                1: begin blk[p] = $urandom_range(0, 1) ? TxPadA : TxPadB; len = 1; end
                2: begin
                    len = 6;
                    if (p + len > 63) break;
                    blk[p] = 8'h01;
                    blk[p + 1] = {2'($urandom), 6'($urandom_range(2, 3))};
                    blk[p + 2] = $urandom_range(0, 1) ? CmdInfo : CmdInfoB;
                end
                3: begin
                    len = 7;
                    if (p + len > 63) break;
                    blk[p] = 8'h01;
                    blk[p + 1] = {2'($urandom), 6'($urandom_range(3, 4))};
                    blk[p + 2] = CmdPad;
                end
                4, 5: begin
                    len = 38;
                    if (p + len > 63) break;
                    a = pick_addr();
                    blk[p] = 8'h03;
                    blk[p + 1] = {2'($urandom), 6'($urandom_range(32, 33))};
                    blk[p + 2] = CmdRead;
                    blk[p + 3] = a[15:8];
                    blk[p + 4] = a[7:0];
                end
                6, 7: begin
                    len = 38;
                    if (p + len > 63) break;
                    a = pick_addr();
                    blk[p] = 8'd35;
                    blk[p + 1] = {2'($urandom), 6'($urandom_range(0, 1))};
                    blk[p + 2] = CmdWrite;
                    blk[p + 3] = a[15:8];
                    blk[p + 4] = a[7:0];
                    if ($urandom_range(0, 2) == 0) blk[p + 5] = 8'h00;
                end
                8: begin
                    len = 4;
                    if (p + len > 63) break;
                    blk[p] = 8'h01;
                    blk[p + 1] = 8'h01;
                    blk[p + 2] = 8'($urandom_range(4, 8'hFC));
                end
                default: begin blk[p] = TxEnd; break; end
            endcase
            p += len;
        end
    endtask

    task automatic load_block(input int from, input int upto, input int read_odds);
        for (int k = from; k < upto; k++) begin
            send(ActLoad, blk[k]);
            if (read_odds > 0 && $urandom_range(1, read_odds) == 1) send(ActRead, 8'($urandom));
        end
    endtask

    initial begin
        rst_n = 1'b0;
        cycles = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        pak_inserted_we = 1'b0;
        pak_inserted_wdata = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = ActLoad;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send(ActRead, 8'h00);
        foreach (blk[k]) blk[k] = 8'($urandom);
        blk[0] = TxPadB;
        blk[1] = 8'h01; blk[2] = 8'h03; blk[3] = CmdInfo;
        blk[7] = 8'h01; blk[8] = 8'h04; blk[9] = CmdPad;
        blk[14] = 8'd35; blk[15] = 8'h01; blk[16] = CmdWrite;
        blk[17] = 8'h00; blk[18] = 8'h2A; blk[19] = 8'hFF;
        blk[52] = TxSkip;
        blk[53] = 8'h01; blk[54] = 8'h01; blk[55] = CmdPad;
        blk[57] = TxEnd;
        load_block(0, 5, 0);
        send(ActRead, 8'h00);
        load_block(5, 64, 0);
        send(ActRead, 8'h00);
        set_pak(1'b0);
        send(ActRead, 8'h00);
        set_pak(1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            quiet = (ph == 3);
            make_block();
            if (ph == 1) begin
                hold_req = 1'b1;
                send(ActRead, 8'($urandom));
            end
            load_block(0, 64, 60);
            repeat ($urandom_range(1, 3)) send(ActRead, 8'($urandom));
            if (ph < 3) set_pak(ph[0]);
        end

        drain();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/jcr_pkg.sv
rtl/core/jcr_pak_ram.sv
rtl/core/joybus_command_responder.sv
tb/joybus_command_responder_checker.sv
tb/joybus_command_responder_tb.sv
